[design/brf_pkg.sv]
package brf_pkg;

  localparam int DEPTH_LOG2 = 8;
  localparam int ADDR_W     = DEPTH_LOG2;
  localparam int PTR_W      = DEPTH_LOG2 + 1;
  localparam int CNT_W      = 9;
  localparam int CAPL_W     = 4;
  localparam int PADDR_W    = 3;

  // largest capacity_log2 that the ring can hold, in register width
  localparam logic [CAPL_W-1:0] CAP_MAX =
      CAPL_W'((DEPTH_LOG2 > 15) ? 15 : DEPTH_LOG2);
  localparam logic [CAPL_W-1:0] CAP_RESET = (CAP_MAX < 4'd8) ? CAP_MAX : 4'd8;

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_CAPACITY_LOG2 = '0;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_GET   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  function automatic addr_t ring_addr(ptr_t ptr, ptr_t cap);
    ptr_t masked;
    masked = ptr & (cap - PTR_W'(1));
    return masked[ADDR_W-1:0];
  endfunction

endpackage

[design/brf_if.sv]
interface brf_in_if;
  logic              valid;
  logic              ready;
  brf_pkg::action_t  action;
  logic [7:0]        data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface brf_out_if;
  logic                valid;
  logic                ready;
  brf_pkg::status_t    status;
  logic [7:0]          data_out;
  brf_pkg::cnt_t       fill_count;
  brf_pkg::cnt_t       free_space;

  modport source (output valid, output status, output data_out, output fill_count,
                  output free_space, input ready);
  modport sink   (input valid, input status, input data_out, input fill_count,
                  input free_space, output ready);
endinterface

[design/byte_ring_fifo.sv]
// channel   | dir | fields                                       | accepted when
// ----------+-----+----------------------------------------------+-------------------------
// request   | in  | action, data_in                              | valid && ready
// result    | out | status, data_out, fill_count, free_space     | valid && ready
// apb       | in  | capacity_log2 at byte address 0              | psel && penable && pwrite
//
// one request per cycle while results are taken; the result register loads from
// stage s1 when s1 moves on, with the ring memory read registered at acceptance.
// pointers update at acceptance, so the next request sees them at once.
// reset clears pointers, capacity_log2 (to 8) and the valid flags; ring contents are
// left as they are. a stalled result holds the pipe and, once s1 is full, drops request.ready.
module byte_ring_fifo (
  input  logic                          clk,
  input  logic                          rst,
  brf_in_if.sink                        request,
  brf_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import brf_pkg::*;

  ptr_t              wr_ptr, rd_ptr;
  ptr_t              wr_ptr_next, rd_ptr_next;
  logic [CAPL_W-1:0] cap_log2;
  ptr_t              cap;
  ptr_t              level, level_next;
  logic              accept, cfg_wr, reg_hit;

  status_t           st;
  logic              rd_use, put_ok, rd_ok;
  logic [7:0]        mem_q;

  logic              s1_valid, s1_move;
  status_t           s1_status;
  logic              s1_rd_use;
  cnt_t              s1_fill, s1_free;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CAPACITY_LOG2);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[CAPL_W-1:0] = cap_log2;
    end
  end

  assign cap   = PTR_W'(1) << cap_log2;
  assign level = wr_ptr - rd_ptr;

  assign s1_move       = s1_valid && (!result.valid || result.ready);
  assign request.ready = !s1_valid || s1_move;
  assign accept        = request.valid && request.ready;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    st          = ST_OK;
    rd_use      = 1'b0;
    put_ok      = 1'b0;
    rd_ok       = 1'b0;
    unique case (request.action)
      ACT_PUT: begin
        if (level >= cap) begin
          st = ST_FULL;
        end else begin
          put_ok      = 1'b1;
          wr_ptr_next = wr_ptr + PTR_W'(1);
        end
      end
      ACT_GET, ACT_PEEK: begin
        if (level == '0) begin
          st = ST_EMPTY;
        end else begin
          rd_ok  = 1'b1;
          rd_use = 1'b1;
          if (request.action == ACT_GET) begin
            rd_ptr_next = rd_ptr + PTR_W'(1);
          end
        end
      end
      ACT_CLEAR: begin
        rd_ptr_next = wr_ptr;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign level_next = wr_ptr_next - rd_ptr_next;

  brf_store u_store (
    .clk   (clk),
    .we    (accept && put_ok),
    .waddr (ring_addr(wr_ptr, cap)),
    .wdata (request.data_in),
    .re    (accept && rd_ok),
    .raddr (ring_addr(rd_ptr, cap)),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      cap_log2 <= CAP_RESET;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        // a new capacity empties the queue
        cap_log2 <= (pwdata[CAPL_W-1:0] > CAP_MAX) ? CAP_MAX : pwdata[CAPL_W-1:0];
        wr_ptr   <= '0;
        rd_ptr   <= '0;
      end else if (accept) begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st;
      s1_rd_use <= rd_use;
      s1_fill   <= CNT_W'(level_next);
      s1_free   <= CNT_W'(cap - level_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.status     <= s1_status;
      result.data_out   <= s1_rd_use ? mem_q : 8'd0;
      result.fill_count <= s1_fill;
      result.free_space <= s1_free;
    end
  end

endmodule

[design/brf_store.sv]
module brf_store (
  input  logic                 clk,
  input  logic                 we,
  input  brf_pkg::addr_t       waddr,
  input  logic [7:0]           wdata,
  input  logic                 re,
  input  brf_pkg::addr_t       raddr,
  output logic [7:0]           rdata
);
  import brf_pkg::*;

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
